FILE: design/sdtl_pkg.sv
// ----------------------------------------------------------------------------
// sdtl_pkg: shared types and constants for the descending top-N list
// Field widths, operation codes and the beat that walks the cell chain.
// ----------------------------------------------------------------------------
package sdtl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OP_W      = 2;
	localparam int VALUE_W   = 20;
	localparam int INDEX_W   = 8;
	localparam int COUNT_W   = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// One operation travelling down the chain, one cell per cycle.
	typedef struct packed {
		logic               valid;
		op_t                op;
		logic [VALUE_W-1:0] data;
		logic [INDEX_W-1:0] index;
		logic               acc;
		logic               added;
	} tok_t;

endpackage

FILE: design/sdtl_cell.sv
// ----------------------------------------------------------------------------
// sdtl_cell: one slot of the sorted list
// Holds one entry and applies the passing operation to it, then hands the
// operation on to the next slot through a register.
// ----------------------------------------------------------------------------
module sdtl_cell #(
	parameter int POS = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sdtl_pkg::tok_t tok_i,
	output sdtl_pkg::tok_t tok_o
);
	import sdtl_pkg::*;

	logic [VALUE_W-1:0] entry_q;
	logic [VALUE_W-1:0] entry_d;
	tok_t               tok_d;
	tok_t               tok_q;

	always_comb begin
		entry_d = entry_q;
		tok_d   = tok_i;
		if (tok_i.valid) begin
			case (tok_i.op)
				OP_INSERT: begin
					// A carried value of zero means the insert has finished.
					if (tok_i.data != '0) begin
						if (entry_q == '0) begin
							entry_d     = tok_i.data;
							tok_d.data  = '0;
							tok_d.acc   = 1'b1;
							tok_d.added = 1'b1;
						end else if (entry_q == tok_i.data) begin
							tok_d.data = '0;
							tok_d.acc  = 1'b1;
						end else if (entry_q < tok_i.data) begin
							// Take the new value and carry the displaced one on.
							entry_d     = tok_i.data;
							tok_d.data  = entry_q;
							tok_d.acc   = 1'b1;
							tok_d.added = 1'b1;
						end
					end
				end
				OP_READ: begin
					if (tok_i.index == INDEX_W'(POS)) begin
						tok_d.data = entry_q;
					end
				end
				OP_CLEAR: begin
					entry_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			tok_q   <= '0;
		end else begin
			entry_q <= entry_d;
			tok_q   <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

FILE: design/sorted_descending_topn_list.sv
// ----------------------------------------------------------------------------
// sorted_descending_topn_list: descending top-N table of nonzero values
// Row of DEPTH slot cells; each command walks the row one slot per cycle.
// ----------------------------------------------------------------------------
// Usage: raise start with operation, value and index while busy is low; the
// command beat is taken at that clock edge and busy rises. Insert places a
// nonzero value in descending order (a duplicate is accepted and changes
// nothing, a value below every entry of a full table is rejected), read
// returns the slot at index (zero at or beyond DEPTH), clear empties the
// table.
// The command passes through the chain of DEPTH cells, one cell per cycle,
// and then through the done register; the result beat has done high for
// exactly one cycle, and busy falls in that same cycle, so a new command
// may be given then.
// The receiver cannot stall: each result is valid only while done is high.
// Reset empties the table, zeroes the count and drops any command in flight.
// ----------------------------------------------------------------------------
module sorted_descending_topn_list #(
	parameter int DEPTH = sdtl_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [sdtl_pkg::OP_W-1:0]    operation,
	input  logic [sdtl_pkg::VALUE_W-1:0] value,
	input  logic [sdtl_pkg::INDEX_W-1:0] index,
	output logic                         done,
	output logic                         accepted,
	output logic [sdtl_pkg::VALUE_W-1:0] read_value,
	output logic [sdtl_pkg::COUNT_W-1:0] entry_count
);
	import sdtl_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_t                   chain [DEPTH+1];
	logic [DEPTH-1:0]       chain_valid;
	logic                   busy_q;
	logic                   done_q;
	logic                   acc_q;
	logic [VALUE_W-1:0]     rd_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W+COUNT_W-1:0] count_ext;
	tok_t                   tail;

	assign chain[0].valid = start && !busy_q;
	assign chain[0].op    = op_t'(operation);
	assign chain[0].data  = (operation == OP_INSERT) ? value : '0;
	assign chain[0].index = index;
	assign chain[0].acc   = (operation == OP_READ) || (operation == OP_CLEAR);
	assign chain[0].added = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sdtl_cell #(
			.POS(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.tok_i (chain[i]),
			.tok_o (chain[i+1])
		);
		assign chain_valid[i] = chain[i+1].valid;
	end

	assign tail = chain[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= tail.valid;
			if (chain[0].valid) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				if (tail.op == OP_CLEAR) begin
					count_q <= '0;
				end else if (tail.op == OP_INSERT && tail.added &&
					count_q != CNT_W'(DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			acc_q <= tail.acc;
			rd_q  <= (tail.op == OP_READ) ? tail.data : '0;
		end
	end

	assign count_ext   = {{COUNT_W{1'b0}}, count_q};
	assign busy        = busy_q;
	assign done        = done_q;
	assign accepted    = acc_q;
	assign read_value  = rd_q;
	assign entry_count = count_ext[COUNT_W-1:0];

	// Exactly one command is in the chain while busy, none otherwise.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot(chain_valid))
		else $error("busy without exactly one command in the cell chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> chain_valid == '0)
		else $error("command in the cell chain while idle");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result beat while still busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> $stable(count_q))
		else $error("entry count changed without a result beat");

endmodule
